[sv/rptc_pkg.sv]
`default_nettype none
package rptc_pkg;

	localparam int SLOTS_DEF        = 8;
	localparam int ADDRESS_BITS_DEF = 16;
	localparam int AGE_BITS_DEF     = 8;

	localparam logic [7:0] KEY_BIG   = 8'h01;
	localparam logic [7:0] KEY_SMALL = 8'h03;

	typedef enum logic {
		FUNC_LEARN = 1'b0,
		FUNC_CHECK = 1'b1
	} rptc_func_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_BIG   = 2'd1,
		KIND_SMALL = 2'd2
	} rptc_kind_t;

	typedef enum logic [2:0] {
		STAT_IGNORED  = 3'd0,
		STAT_UNPAIRED = 3'd1,
		STAT_REFRESH  = 3'd2,
		STAT_STORED   = 3'd3,
		STAT_REPLACED = 3'd4,
		STAT_MATCH    = 3'd5,
		STAT_NO_MATCH = 3'd6
	} rptc_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_AGE,
		S_AGE_DRAIN,
		S_RESULT
	} rptc_state_t;

endpackage
`default_nettype wire

[sv/rptc_table.sv]
`default_nettype none
module rptc_table #(
	parameter int SLOTS        = rptc_pkg::SLOTS_DEF,
	parameter int ADDRESS_BITS = rptc_pkg::ADDRESS_BITS_DEF,
	parameter int AGE_BITS     = rptc_pkg::AGE_BITS_DEF,
	parameter int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [IDX_W-1:0]        rd_idx,
	output logic                         rd_valid,
	output logic [ADDRESS_BITS-1:0]      rd_addr,
	output logic [AGE_BITS-1:0]          rd_age,
	output logic [1:0]                   rd_kind,
	input  wire logic                    wr_en,
	input  wire logic [IDX_W-1:0]        wr_idx,
	input  wire logic [ADDRESS_BITS-1:0] wr_addr,
	input  wire logic [AGE_BITS-1:0]     wr_age,
	input  wire logic [1:0]              wr_kind
);
	import rptc_pkg::*;

	logic [ADDRESS_BITS-1:0] addr_mem [SLOTS];
	logic [AGE_BITS-1:0]     age_mem  [SLOTS];
	logic [1:0]              kind_mem [SLOTS];
	logic [SLOTS-1:0]        valid_q;

	logic [ADDRESS_BITS-1:0] rd_addr_q;
	logic [AGE_BITS-1:0]     rd_age_q;
	logic [1:0]              rd_kind_q;
	logic                    rd_valid_q;

	// A slot only counts as occupied once a non-zero address has been written to it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= (wr_addr != '0);
			end
			rd_valid_q <= valid_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_mem[wr_idx] <= wr_addr;
			age_mem[wr_idx]  <= wr_age;
			kind_mem[wr_idx] <= wr_kind;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= addr_mem[rd_idx];
		rd_age_q  <= age_mem[rd_idx];
		rd_kind_q <= kind_mem[rd_idx];
	end

	assign rd_valid = rd_valid_q;
	assign rd_addr  = rd_valid_q ? rd_addr_q : '0;
	assign rd_age   = rd_valid_q ? rd_age_q : '0;
	assign rd_kind  = rd_valid_q ? rd_kind_q : KIND_NONE;

endmodule
`default_nettype wire

[sv/rptc_seq.sv]
`default_nettype none
module rptc_seq #(
	parameter int SLOTS        = rptc_pkg::SLOTS_DEF,
	parameter int ADDRESS_BITS = rptc_pkg::ADDRESS_BITS_DEF,
	parameter int AGE_BITS     = rptc_pkg::AGE_BITS_DEF,
	parameter int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    func,
	input  wire logic [ADDRESS_BITS-1:0] remote_address,
	input  wire logic [7:0]              key_code,
	input  wire logic                    unpair_enable,
	output logic                         busy,
	output logic                         done,
	output logic [2:0]                   status,
	output logic [2:0]                   slot_index,
	output logic [1:0]                   remote_kind,
	output logic [IDX_W-1:0]             rd_idx,
	input  wire logic                    rd_valid,
	input  wire logic [ADDRESS_BITS-1:0] rd_addr,
	input  wire logic [AGE_BITS-1:0]     rd_age,
	input  wire logic [1:0]              rd_kind,
	output logic                         wr_en,
	output logic [IDX_W-1:0]             wr_idx,
	output logic [ADDRESS_BITS-1:0]      wr_addr,
	output logic [AGE_BITS-1:0]          wr_age,
	output logic [1:0]                   wr_kind
);
	import rptc_pkg::*;

	localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};

	rptc_state_t state_q, state_d;

	rptc_func_t              func_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	rptc_kind_t              kind_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    scan_v_s1;
	logic                    age_v_s1;
	logic [IDX_W-1:0]        idx_s1;

	logic                    match_found_q;
	logic [IDX_W-1:0]        match_idx_q;
	logic [1:0]              match_kind_q;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic [AGE_BITS-1:0]     best_age_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic [IDX_W-1:0]        target_q;

	rptc_status_t            status_q;
	logic [2:0]              res_idx_q;
	logic [1:0]              res_kind_q;

	logic                    accept;
	rptc_kind_t              in_kind;
	logic                    in_early;
	rptc_status_t            early_status;

	rptc_status_t            dec_status;
	logic [IDX_W-1:0]        dec_idx;
	logic [1:0]              dec_kind;
	logic [ADDRESS_BITS-1:0] dec_addr;
	logic                    dec_age_pass;

	logic                    age_hit;

	assign accept = (state_q == S_IDLE) && start;

	always_comb begin
		if (key_code == KEY_BIG) begin
			in_kind = KIND_BIG;
		end else if (key_code == KEY_SMALL) begin
			in_kind = KIND_SMALL;
		end else begin
			in_kind = KIND_NONE;
		end
	end

	// Ignored learns and checks of the empty address need no walk over the table.
	always_comb begin
		if (rptc_func_t'(func) == FUNC_CHECK) begin
			in_early     = (remote_address == '0);
			early_status = STAT_NO_MATCH;
		end else begin
			in_early     = (in_kind == KIND_NONE) || (remote_address == '0);
			early_status = STAT_IGNORED;
		end
	end

	always_comb begin
		dec_age_pass = 1'b1;
		dec_addr     = addr_q;
		if (func_q == FUNC_CHECK) begin
			dec_age_pass = 1'b0;
			if (match_found_q) begin
				dec_status = STAT_MATCH;
				dec_idx    = match_idx_q;
				dec_kind   = match_kind_q;
			end else begin
				dec_status = STAT_NO_MATCH;
				dec_idx    = '0;
				dec_kind   = KIND_NONE;
			end
		end else if (match_found_q) begin
			dec_idx = match_idx_q;
			if (unpair_enable) begin
				dec_status   = STAT_UNPAIRED;
				dec_kind     = KIND_NONE;
				dec_addr     = '0;
				dec_age_pass = 1'b0;
			end else begin
				dec_status = STAT_REFRESH;
				dec_kind   = kind_q;
			end
		end else if (free_found_q) begin
			dec_status = STAT_STORED;
			dec_idx    = free_idx_q;
			dec_kind   = kind_q;
		end else begin
			dec_status = STAT_REPLACED;
			dec_idx    = best_idx_q;
			dec_kind   = kind_q;
		end
	end

	assign age_hit = age_v_s1 && rd_valid && (idx_s1 != target_q) && (rd_age != AGE_MAX);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = in_early ? S_RESULT : S_SCAN;
				end
			end
			S_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:  state_d = S_DECIDE;
			S_DECIDE: state_d = dec_age_pass ? S_AGE : S_RESULT;
			S_AGE: begin
				if (idx_q == LAST_IDX) begin
					state_d = S_AGE_DRAIN;
				end
			end
			S_AGE_DRAIN: state_d = S_RESULT;
			S_RESULT:    state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy    = (state_q != S_IDLE);
		done    = (state_q == S_RESULT);
		rd_idx  = idx_q;
		wr_en   = 1'b0;
		wr_idx  = idx_s1;
		wr_addr = rd_addr;
		wr_age  = rd_age + AGE_BITS'(1);
		wr_kind = rd_kind;
		unique case (state_q)
			S_DECIDE: begin
				wr_en   = (func_q == FUNC_LEARN);
				wr_idx  = dec_idx;
				wr_addr = dec_addr;
				wr_age  = '0;
				wr_kind = dec_kind;
			end
			S_AGE, S_AGE_DRAIN: begin
				wr_en = age_hit;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			scan_v_s1 <= 1'b0;
			age_v_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= (state_q == S_SCAN);
			age_v_s1  <= (state_q == S_AGE);
			if (state_q == S_SCAN || state_q == S_AGE) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			func_q        <= rptc_func_t'(func);
			addr_q        <= remote_address;
			kind_q        <= in_kind;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			match_kind_q  <= KIND_NONE;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			best_age_q    <= '0;
			best_idx_q    <= '0;
			status_q      <= early_status;
			res_idx_q     <= '0;
			res_kind_q    <= KIND_NONE;
		end
		if (scan_v_s1) begin
			if (!match_found_q && rd_valid && rd_addr == addr_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_s1;
				match_kind_q  <= rd_kind;
			end
			if (!free_found_q && !rd_valid) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (rd_age > best_age_q) begin
				best_age_q <= rd_age;
				best_idx_q <= idx_s1;
			end
		end
		if (state_q == S_DECIDE) begin
			target_q   <= dec_idx;
			status_q   <= dec_status;
			res_idx_q  <= 3'(dec_idx);
			res_kind_q <= dec_kind;
		end
	end

	assign status      = status_q;
	assign slot_index  = res_idx_q;
	assign remote_kind = res_kind_q;

endmodule
`default_nettype wire

[sv/remote_pairing_table_by_count_unit.sv]
// A learn that stores, refreshes or replaces walks the table twice before its done strobe,
// once to search and once to age; a check or an unpair walks it only once, and an ignored key
// or the empty address goes straight to the result. A new word is taken only once the
// previous one has given its done strobe and the unit is idle again.
// The results cannot be stalled. Reset clears the sequencer, the register and the slot valid
// bits at once, so the table reads empty with no clearing pass.
`default_nettype none
module remote_pairing_table_by_count_unit #(
	parameter int SLOTS        = rptc_pkg::SLOTS_DEF,
	parameter int ADDRESS_BITS = rptc_pkg::ADDRESS_BITS_DEF,
	parameter int AGE_BITS     = rptc_pkg::AGE_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    func,
	input  wire logic [ADDRESS_BITS-1:0] remote_address,
	input  wire logic [7:0]              key_code,
	output logic                         done,
	output logic [2:0]                   status,
	output logic [2:0]                   slot_index,
	output logic [1:0]                   remote_kind,
	input  wire logic                    cfg_write,
	input  wire logic                    cfg_data
);
	import rptc_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic                    unpair_enable_q;
	logic [IDX_W-1:0]        rd_idx;
	logic                    rd_valid;
	logic [ADDRESS_BITS-1:0] rd_addr;
	logic [AGE_BITS-1:0]     rd_age;
	logic [1:0]              rd_kind;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_idx;
	logic [ADDRESS_BITS-1:0] wr_addr;
	logic [AGE_BITS-1:0]     wr_age;
	logic [1:0]              wr_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unpair_enable_q <= 1'b0;
		end else if (cfg_write) begin
			unpair_enable_q <= cfg_data;
		end
	end

	rptc_seq #(
		.SLOTS        (SLOTS),
		.ADDRESS_BITS (ADDRESS_BITS),
		.AGE_BITS     (AGE_BITS),
		.IDX_W        (IDX_W)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.func           (func),
		.remote_address (remote_address),
		.key_code       (key_code),
		.unpair_enable  (unpair_enable_q),
		.busy           (busy),
		.done           (done),
		.status         (status),
		.slot_index     (slot_index),
		.remote_kind    (remote_kind),
		.rd_idx         (rd_idx),
		.rd_valid       (rd_valid),
		.rd_addr        (rd_addr),
		.rd_age         (rd_age),
		.rd_kind        (rd_kind),
		.wr_en          (wr_en),
		.wr_idx         (wr_idx),
		.wr_addr        (wr_addr),
		.wr_age         (wr_age),
		.wr_kind        (wr_kind)
	);

	rptc_table #(
		.SLOTS        (SLOTS),
		.ADDRESS_BITS (ADDRESS_BITS),
		.AGE_BITS     (AGE_BITS),
		.IDX_W        (IDX_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_valid (rd_valid),
		.rd_addr  (rd_addr),
		.rd_age   (rd_age),
		.rd_kind  (rd_kind),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_addr  (wr_addr),
		.wr_age   (wr_age),
		.wr_kind  (wr_kind)
	);

endmodule
`default_nettype wire

[sv/rptc_checker.sv]
`default_nettype none
module rptc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [2:0] status,
	input wire logic [2:0] slot_index,
	input wire logic [1:0] remote_kind
);
	import rptc_pkg::*;

	// A result word only appears while a request is in progress.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result word outside a request");

	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	assert property (@(posedge clk) disable iff (!arst_n) done |=> (!done && !busy))
		else $error("result strobe longer than one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_IGNORED || status == STAT_NO_MATCH || status == STAT_UNPAIRED))
		|-> (remote_kind == KIND_NONE))
		else $error("kind reported for an empty slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_IGNORED || status == STAT_NO_MATCH)) |-> (slot_index == 3'd0))
		else $error("slot index reported without a slot");

endmodule

bind remote_pairing_table_by_count_unit rptc_checker u_rptc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.slot_index  (slot_index),
	.remote_kind (remote_kind)
);
`default_nettype wire
